// ----- rtl/core/ptq_pkg.sv -----
`default_nettype none

package ptq_pkg;

	localparam int DEF_TIMER_SLOTS   = 16;
	localparam int DEF_WAIT_CLAMP_MS = 1000;

	// most results a single tick may emit
	localparam int RESULT_LIMIT   = 16;
	localparam int RB_W           = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;
	localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);
	localparam int WAIT_W         = 10;
	localparam int WAIT_FIELD_MAX = (1 << WAIT_W) - 1;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_DELETED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FIRED     = 3'd5,
		ST_NO_FIRE   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SCAN_FIND = 2'd0,
		SCAN_PEND = 2'd1,
		SCAN_PICK = 2'd2,
		SCAN_WAIT = 2'd3
	} scan_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_APPLY,
		S_PEND_GO,
		S_PEND,
		S_PICK,
		S_FIRE,
		S_WAIT,
		S_EMIT_RD,
		S_EMIT_LD
	} ctrl_state_t;

	typedef struct packed {
		logic       load_in;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       time_inc;
		logic       add_write;
		logic       del_clear;
		logic       fire_update;
	} tbl_cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic scan_done;
		logic found;
		logic free_ok;
		logic pick_any;
	} tbl_stat_t;

	typedef struct packed {
		logic [15:0]       in_id;
		logic [15:0]       pick_id;
		logic [23:0]       pick_delay;
		logic [23:0]       pick_reload;
		logic [WAIT_W-1:0] next_wait;
	} tbl_data_t;

	typedef struct packed {
		logic    clear;
		logic    push;
		status_t push_status;
		logic    use_pick;
		logic    emit_read;
		logic    emit_load;
	} res_cmd_t;

	typedef struct packed {
		logic             last_room;
		logic             empty;
		logic             emit_last;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} res_stat_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] id;
		logic [23:0] delay;
		logic [23:0] reload;
	} res_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptq_table.sv -----
`default_nettype none

module ptq_table #(
	parameter int TIMER_SLOTS   = ptq_pkg::DEF_TIMER_SLOTS,
	parameter int WAIT_CLAMP_MS = ptq_pkg::DEF_WAIT_CLAMP_MS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptq_pkg::tbl_cmd_t  cmd,
	input  logic [15:0]        in_id,
	input  logic [23:0]        in_delay,
	input  logic [23:0]        in_reload,
	output ptq_pkg::tbl_stat_t stat,
	output ptq_pkg::tbl_data_t data
);
	import ptq_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
	localparam int CLAMP = (WAIT_CLAMP_MS < WAIT_FIELD_MAX) ? WAIT_CLAMP_MS : WAIT_FIELD_MAX;
	localparam logic [31:0] CLAMP_W = 32'(CLAMP);

	logic [15:0] mem_id     [TIMER_SLOTS];
	logic [31:0] mem_due    [TIMER_SLOTS];
	logic [23:0] mem_delay  [TIMER_SLOTS];
	logic [23:0] mem_reload [TIMER_SLOTS];

	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] pend_q;
	logic [31:0]            time_q;

	logic [15:0] in_id_q;
	logic [23:0] in_delay_q;
	logic [23:0] in_reload_q;

	logic             run_q;
	logic [IDX_W-1:0] idx_q;
	scan_mode_t       mode_q;

	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic             pend_s1;
	logic [15:0]      rd_id_s1;
	logic [31:0]      rd_due_s1;
	logic [23:0]      rd_delay_s1;
	logic [23:0]      rd_reload_s1;

	logic             found_q;
	logic             free_ok_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             pick_any_q;
	logic [IDX_W-1:0] pick_idx_q;
	logic [31:0]      best_key_q;
	logic [15:0]      best_id_q;
	logic [23:0]      best_delay_q;
	logic [23:0]      best_reload_q;
	logic             wait_any_q;
	logic [31:0]      wait_min_q;

	logic [31:0]      diff;
	logic             due_now;
	logic [31:0]      key;
	logic [31:0]      wait_val;
	logic             hit_id;
	logic             take_free;
	logic             take_pick;
	logic             take_wait;
	logic             rearm;
	logic [IDX_W-1:0] wr_idx;

	// wrap-safe order: signed distance from now, biased for an unsigned compare
	assign diff     = rd_due_s1 - time_q;
	assign due_now  = (diff == 32'd0) || diff[31];
	assign key      = diff ^ 32'h8000_0000;
	assign wait_val = due_now ? 32'd0 : diff;

	assign hit_id    = v_s1 && (mode_q == SCAN_FIND) && vld_s1 && (rd_id_s1 == in_id_q)
		&& !found_q;
	assign take_free = v_s1 && (mode_q == SCAN_FIND) && !vld_s1 && !free_ok_q;
	assign take_pick = v_s1 && (mode_q == SCAN_PICK) && pend_s1 && (!pick_any_q
		|| (key < best_key_q) || ((key == best_key_q) && (rd_id_s1 < best_id_q)));
	assign take_wait = v_s1 && (mode_q == SCAN_WAIT) && vld_s1
		&& (!wait_any_q || (wait_val < wait_min_q));

	assign rearm  = cmd.fire_update && (best_reload_q != 24'd0);
	assign wr_idx = cmd.add_write ? free_idx_q : pick_idx_q;

	assign stat.scan_busy = run_q || v_s1;
	assign stat.scan_done = v_s1 && (idx_s1 == LAST_IDX);
	assign stat.found     = found_q;
	assign stat.free_ok   = free_ok_q;
	assign stat.pick_any  = pick_any_q;

	assign data.in_id       = in_id_q;
	assign data.pick_id     = best_id_q;
	assign data.pick_delay  = best_delay_q;
	assign data.pick_reload = best_reload_q;
	assign data.next_wait   = !wait_any_q ? WAIT_W'(1)
		: ((wait_min_q > CLAMP_W) ? WAIT_W'(CLAMP) : wait_min_q[WAIT_W-1:0]);

	// slot scan: one slot per cycle, read data lands in the _s1 stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			idx_q  <= '0;
			mode_q <= SCAN_FIND;
			v_s1   <= 1'b0;
			idx_s1 <= '0;
		end else begin
			if (cmd.scan_start) begin
				run_q  <= 1'b1;
				idx_q  <= '0;
				mode_q <= cmd.scan_mode;
			end else if (run_q) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == LAST_IDX) begin
					run_q <= 1'b0;
				end
			end
			v_s1   <= run_q;
			idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_id_s1     <= mem_id[idx_q];
		rd_due_s1    <= mem_due[idx_q];
		rd_delay_s1  <= mem_delay[idx_q];
		rd_reload_s1 <= mem_reload[idx_q];
		vld_s1       <= valid_q[idx_q];
		pend_s1      <= pend_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			mem_id[wr_idx]     <= in_id_q;
			mem_reload[wr_idx] <= in_reload_q;
			mem_due[wr_idx]    <= time_q + 32'(in_delay_q);
			mem_delay[wr_idx]  <= in_delay_q;
		end else if (rearm) begin
			mem_due[wr_idx]   <= time_q + 32'(best_reload_q);
			mem_delay[wr_idx] <= best_reload_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			valid_q    <= '0;
			pend_q     <= '0;
			found_q    <= 1'b0;
			free_ok_q  <= 1'b0;
			pick_any_q <= 1'b0;
			wait_any_q <= 1'b0;
		end else begin
			if (cmd.time_inc) begin
				time_q <= time_q + 32'd1;
			end
			if (cmd.add_write) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.del_clear) begin
				valid_q[found_idx_q] <= 1'b0;
			end
			if (cmd.fire_update) begin
				pend_q[pick_idx_q] <= 1'b0;
				if (!rearm) begin
					valid_q[pick_idx_q] <= 1'b0;
				end
			end
			if (cmd.scan_start) begin
				case (cmd.scan_mode)
					SCAN_FIND: begin
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
					end
					SCAN_PICK: pick_any_q <= 1'b0;
					SCAN_WAIT: wait_any_q <= 1'b0;
					default: ;
				endcase
			end
			if (v_s1 && (mode_q == SCAN_PEND)) begin
				pend_q[idx_s1] <= vld_s1 && due_now;
			end
			if (hit_id) begin
				found_q <= 1'b1;
			end
			if (take_free) begin
				free_ok_q <= 1'b1;
			end
			if (take_pick) begin
				pick_any_q <= 1'b1;
			end
			if (take_wait) begin
				wait_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_id_q     <= in_id;
			in_delay_q  <= in_delay;
			in_reload_q <= in_reload;
		end
		if (hit_id) begin
			found_idx_q <= idx_s1;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (take_pick) begin
			pick_idx_q    <= idx_s1;
			best_key_q    <= key;
			best_id_q     <= rd_id_s1;
			best_delay_q  <= rd_delay_s1;
			best_reload_q <= rd_reload_s1;
		end
		if (take_wait) begin
			wait_min_q <= wait_val;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ptq_results.sv -----
`default_nettype none

module ptq_results (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptq_pkg::res_cmd_t        cmd,
	input  ptq_pkg::tbl_data_t       tdat,
	output ptq_pkg::res_stat_t       stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ptq_pkg::status_t         out_status,
	output logic [15:0]              out_id,
	output logic [23:0]              out_delay,
	output logic [23:0]              out_reload,
	output logic [ptq_pkg::WAIT_W-1:0] out_wait,
	output logic                     out_last
);
	import ptq_pkg::*;

	res_entry_t buf_mem [RESULT_LIMIT];

	logic [CNT_W-1:0] count_q;
	logic [RB_W-1:0]  rd_idx_q;
	res_entry_t       rd_s1;
	res_entry_t       entry;
	logic             out_valid_q;
	res_entry_t       out_q;
	logic [WAIT_W-1:0] out_wait_q;
	logic             out_last_q;

	// an empty tick reports id zero
	always_comb begin
		entry.status = cmd.push_status;
		entry.id     = cmd.use_pick ? tdat.pick_id
			: ((cmd.push_status == ST_NO_FIRE) ? 16'd0 : tdat.in_id);
		entry.delay  = cmd.use_pick ? tdat.pick_delay : 24'd0;
		entry.reload = cmd.use_pick ? tdat.pick_reload : 24'd0;
	end

	assign stat.last_room = (count_q == CNT_W'(RESULT_LIMIT - 1));
	assign stat.empty     = (count_q == '0);
	assign stat.emit_last = (CNT_W'(rd_idx_q) == (count_q - CNT_W'(1)));
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.count     = count_q;

	assign out_valid  = out_valid_q;
	assign out_status = out_q.status;
	assign out_id     = out_q.id;
	assign out_delay  = out_q.delay;
	assign out_reload = out_q.reload;
	assign out_wait   = out_wait_q;
	assign out_last   = out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			buf_mem[count_q[RB_W-1:0]] <= entry;
		end
		if (cmd.emit_read) begin
			rd_s1 <= buf_mem[rd_idx_q];
		end
		if (cmd.emit_load) begin
			out_q      <= rd_s1;
			out_wait_q <= tdat.next_wait;
			out_last_q <= stat.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q  <= '0;
				rd_idx_q <= '0;
			end else begin
				if (cmd.push) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.emit_load) begin
					rd_idx_q <= rd_idx_q + RB_W'(1);
				end
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ptq_ctrl.sv -----
`default_nettype none

module ptq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ptq_pkg::kind_t     in_kind,
	output logic               in_ready,
	input  ptq_pkg::tbl_stat_t tstat,
	input  ptq_pkg::res_stat_t rstat,
	output ptq_pkg::tbl_cmd_t  tcmd,
	output ptq_pkg::res_cmd_t  rcmd
);
	import ptq_pkg::*;

	ctrl_state_t state_q, state_d;
	kind_t       kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_NONE;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				kind_q <= in_kind;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		tcmd     = '0;
		rcmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					tcmd.load_in = 1'b1;
					if (in_kind inside {KIND_ADD, KIND_DEL}) begin
						rcmd.clear      = 1'b1;
						tcmd.scan_start = 1'b1;
						tcmd.scan_mode  = SCAN_FIND;
						state_d         = S_FIND;
					end else if (in_kind == KIND_TICK) begin
						rcmd.clear    = 1'b1;
						tcmd.time_inc = 1'b1;
						state_d       = S_PEND_GO;
					end
				end
			end
			S_FIND: begin
				if (tstat.scan_done) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				rcmd.push = 1'b1;
				if (kind_q == KIND_ADD) begin
					if (tstat.found) begin
						rcmd.push_status = ST_DUPLICATE;
					end else if (!tstat.free_ok) begin
						rcmd.push_status = ST_FULL;
					end else begin
						rcmd.push_status = ST_ADDED;
						tcmd.add_write   = 1'b1;
					end
				end else begin
					if (tstat.found) begin
						rcmd.push_status = ST_DELETED;
						tcmd.del_clear   = 1'b1;
					end else begin
						rcmd.push_status = ST_NOT_FOUND;
					end
				end
				tcmd.scan_start = 1'b1;
				tcmd.scan_mode  = SCAN_WAIT;
				state_d         = S_WAIT;
			end
			S_PEND_GO: begin
				tcmd.scan_start = 1'b1;
				tcmd.scan_mode  = SCAN_PEND;
				state_d         = S_PEND;
			end
			S_PEND: begin
				if (tstat.scan_done) begin
					tcmd.scan_start = 1'b1;
					tcmd.scan_mode  = SCAN_PICK;
					state_d         = S_PICK;
				end
			end
			S_PICK: begin
				if (tstat.scan_done) begin
					state_d = S_FIRE;
				end
			end
			S_FIRE: begin
				tcmd.scan_start = 1'b1;
				if (tstat.pick_any) begin
					tcmd.fire_update = 1'b1;
					rcmd.push        = 1'b1;
					rcmd.push_status = ST_FIRED;
					rcmd.use_pick    = 1'b1;
					// stop at the per-tick limit; leftovers stay pending for later ticks
					if (rstat.last_room) begin
						tcmd.scan_mode = SCAN_WAIT;
						state_d        = S_WAIT;
					end else begin
						tcmd.scan_mode = SCAN_PICK;
						state_d        = S_PICK;
					end
				end else begin
					if (rstat.empty) begin
						rcmd.push        = 1'b1;
						rcmd.push_status = ST_NO_FIRE;
					end
					tcmd.scan_mode = SCAN_WAIT;
					state_d        = S_WAIT;
				end
			end
			S_WAIT: begin
				if (tstat.scan_done) begin
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				rcmd.emit_read = 1'b1;
				state_d        = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (rstat.out_free) begin
					rcmd.emit_load = 1'b1;
					state_d        = rstat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/periodic_timer_scheduler.sv -----
`default_nettype none

// Timer queue with TIMER_SLOTS entries and a millisecond counter. Every word
// in (add, delete or tick) is handled to completion before the next is taken;
// the slot table sits in a memory with one read port and is walked one slot a
// cycle, which sets the rate. Add and delete make one pass that finds the id
// and a free slot, then one pass that finds the next wait. A tick that fires F
// timers (F up to 16) makes these passes: one pass marks the due timers, one
// pass per fired timer picks the earliest (plus one that finds none left, not
// made when F reaches 16), one pass finds the next wait. Output stalls hold
// up the emit. Results of a word are buffered and then streamed out one at a
// time, each read from the buffer and then loaded into the output register,
// all carrying the same next_wait_ms; the input is ready again once the final
// result sits in the output register. No clearing pass after reset.
module periodic_timer_scheduler #(
	parameter int TIMER_SLOTS   = ptq_pkg::DEF_TIMER_SLOTS,
	parameter int WAIT_CLAMP_MS = ptq_pkg::DEF_WAIT_CLAMP_MS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // timer_id[15:0], delay_ms[39:16], reload_ms[63:40]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // fired_id[15:0], fired_delay[39:16],
	                              // fired_reload[63:40], next_wait_ms[73:64], zero
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast   // last
);
	import ptq_pkg::*;

	tbl_cmd_t  tb_cmd;
	tbl_stat_t tb_stat;
	tbl_data_t tb_data;
	res_cmd_t  rs_cmd;
	res_stat_t rs_stat;

	status_t           o_status;
	logic [15:0]       o_id;
	logic [23:0]       o_delay;
	logic [23:0]       o_reload;
	logic [WAIT_W-1:0] o_wait;

	ptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (kind_t'(s_tuser)),
		.in_ready (s_tready),
		.tstat    (tb_stat),
		.rstat    (rs_stat),
		.tcmd     (tb_cmd),
		.rcmd     (rs_cmd)
	);

	ptq_table #(
		.TIMER_SLOTS   (TIMER_SLOTS),
		.WAIT_CLAMP_MS (WAIT_CLAMP_MS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tb_cmd),
		.in_id     (s_tdata[15:0]),
		.in_delay  (s_tdata[39:16]),
		.in_reload (s_tdata[63:40]),
		.stat      (tb_stat),
		.data      (tb_data)
	);

	ptq_results u_results (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (rs_cmd),
		.tdat       (tb_data),
		.stat       (rs_stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (o_status),
		.out_id     (o_id),
		.out_delay  (o_delay),
		.out_reload (o_reload),
		.out_wait   (o_wait),
		.out_last   (m_tlast)
	);

	assign m_tuser = o_status;
	assign m_tdata = {6'd0, o_wait, o_reload, o_delay, o_id};

	// input is only taken with the table walk at rest
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !tb_stat.scan_busy)
		else $error("input ready while a slot scan runs");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rs_stat.count <= CNT_W'(RESULT_LIMIT))
		else $error("result buffer overfilled");

	// add, delete and an empty tick each give a single word
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ADDED || m_tuser == ST_DUPLICATE || m_tuser == ST_FULL
		|| m_tuser == ST_DELETED || m_tuser == ST_NOT_FOUND || m_tuser == ST_NO_FIRE)
		|-> m_tlast)
		else $error("single-word result without last");

	a_fire_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_FIRED) |-> (m_tdata[63:16] == 48'd0))
		else $error("non-fire result carries delay or reload");

endmodule

`default_nettype wire
